// File: rtl/wsd_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the websocket frame deframer
package wsd_pkg;

  localparam int COUNT_BITS  = 16;
  localparam int CFG_BITS    = 16;
  localparam int CMP_BITS    = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] OPCODE_MASK = 8'h0F;
  localparam logic [6:0] LEN_EXT16   = 7'd126;
  localparam logic [6:0] LEN_EXT64   = 7'd127;
  localparam logic [2:0] EXT16_BYTES = 3'd1;
  localparam logic [2:0] EXT64_BYTES = 3'd7;
  localparam logic [2:0] KEY_BYTES   = 3'd3;

  localparam logic REG_MAX_PAYLOAD = 1'b0;
  localparam logic [CFG_BITS-1:0] MAX_PAYLOAD_RESET = 16'd4080;

  typedef enum logic [2:0] {
    KIND_HDR      = 3'd0,
    KIND_DATA     = 3'd1,
    KIND_EMPTY    = 3'd2,
    KIND_OVERSIZE = 3'd3,
    KIND_HALTED   = 3'd4
  } kind_t;

  typedef enum logic [5:0] {
    PH_HDR0   = 6'b000001,
    PH_HDR1   = 6'b000010,
    PH_EXTLEN = 6'b000100,
    PH_KEY    = 6'b001000,
    PH_DATA   = 6'b010000,
    PH_HALT   = 6'b100000
  } phase_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] raw;
    logic [7:0] key_byte;
    logic [3:0] opcode;
    logic       last;
  } entry_t;

endpackage

// File: rtl/websocket_frame_deframer.sv
`timescale 1ns / 1ps
// top level of the websocket frame deframer
//
//  channel   handshake                     payload
//  input     push / full                   rx_byte
//  result    pop / empty                   kind, data_byte, frame_opcode, frame_last
//  config    psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// one word accepted per cycle while full is low; each word gives one result word
// result word reaches the output via queue and output register after its input word is accepted
// queue of four words lets input continue while the result side stalls
// rst clears parse state, queue and output; limit returns to 4080
// after an oversize frame every word reports halted until reset
module websocket_frame_deframer
  import wsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        push,
  input  logic [7:0]  rx_byte,
  output logic        full,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  kind,
  output logic [7:0]  data_byte,
  output logic [3:0]  frame_opcode,
  output logic        frame_last
);

  logic [CFG_BITS-1:0] max_payload;
  logic                acc;
  entry_t              ent;
  entry_t              q_data;
  logic                q_rd;
  logic                q_empty;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_PAYLOAD) ? 32'(max_payload) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= MAX_PAYLOAD_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_MAX_PAYLOAD)) begin
      max_payload <= pwdata[CFG_BITS-1:0];
    end
  end

  assign acc = push && !full;

  wsd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .acc         (acc),
    .rx_byte     (rx_byte),
    .max_payload (max_payload),
    .ent         (ent)
  );

  wsd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (acc),
    .wr_data (ent),
    .rd      (q_rd),
    .rd_data (q_data),
    .q_full  (full),
    .q_empty (q_empty)
  );

  wsd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_data       (q_data),
    .q_rd         (q_rd),
    .pop          (pop),
    .empty        (empty),
    .kind         (kind),
    .data_byte    (data_byte),
    .frame_opcode (frame_opcode),
    .frame_last   (frame_last)
  );

endmodule

// File: rtl/wsd_front.sv
`timescale 1ns / 1ps
// header parser: classifies each received word and tracks frame state
module wsd_front
  import wsd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                acc,
  input  logic [7:0]          rx_byte,
  input  logic [CFG_BITS-1:0] max_payload,
  output entry_t              ent
);

  phase_t                phase, phase_next;
  logic [3:0]            opcode, opcode_next;
  logic                  mask_on, mask_on_next;
  logic [COUNT_BITS-1:0] len_low, len_low_next;
  logic                  len_big, len_big_next;
  logic [2:0]            hdr_cnt, hdr_cnt_next;
  logic [31:0]           key, key_next;
  logic [COUNT_BITS-1:0] idx, idx_next;

  logic                  known;
  logic [COUNT_BITS-1:0] kl;
  logic                  kb;
  logic                  km;
  logic [6:0]            len7;
  logic [COUNT_BITS+7:0] shifted;
  logic [COUNT_BITS-1:0] idx_inc;
  logic [7:0]            kbyte;
  logic [CMP_BITS-1:0]   max_ext, mask_ext, limit_ext;

  assign max_ext   = CMP_BITS'(max_payload);
  assign mask_ext  = CMP_BITS'({COUNT_BITS{1'b1}});
  assign limit_ext = (max_ext > mask_ext) ? mask_ext : max_ext;
  assign len7      = rx_byte[6:0];
  assign shifted   = {len_low, rx_byte};
  assign idx_inc   = idx + COUNT_BITS'(1);

  always_comb begin
    case (idx[1:0])
      2'd0: kbyte = key[31:24];
      2'd1: kbyte = key[23:16];
      2'd2: kbyte = key[15:8];
      default: kbyte = key[7:0];
    endcase
  end

  always_comb begin
    phase_next   = phase;
    opcode_next  = opcode;
    mask_on_next = mask_on;
    len_low_next = len_low;
    len_big_next = len_big;
    hdr_cnt_next = hdr_cnt;
    key_next     = key;
    idx_next     = idx;
    known        = 1'b0;
    kl           = len_low;
    kb           = len_big;
    km           = mask_on;
    ent          = '0;
    ent.kind     = KIND_HDR;
    ent.opcode   = opcode;
    unique case (phase)
      PH_HDR0: begin
        opcode_next = rx_byte[3:0] & OPCODE_MASK[3:0];
        ent.opcode  = rx_byte[3:0] & OPCODE_MASK[3:0];
        phase_next  = PH_HDR1;
      end
      PH_HDR1: begin
        mask_on_next = rx_byte[7];
        len_low_next = '0;
        len_big_next = 1'b0;
        if (len7 == LEN_EXT16) begin
          hdr_cnt_next = EXT16_BYTES;
          phase_next   = PH_EXTLEN;
        end else if (len7 == LEN_EXT64) begin
          hdr_cnt_next = EXT64_BYTES;
          phase_next   = PH_EXTLEN;
        end else begin
          len_low_next = COUNT_BITS'(len7);
          known        = 1'b1;
          kl           = COUNT_BITS'(len7);
          kb           = 1'b0;
          km           = rx_byte[7];
        end
      end
      PH_EXTLEN: begin
        len_low_next = shifted[COUNT_BITS-1:0];
        len_big_next = len_big | (len_low[COUNT_BITS-1 -: 8] != 8'd0);
        if (hdr_cnt == 3'd0) begin
          known = 1'b1;
          kl    = shifted[COUNT_BITS-1:0];
          kb    = len_big | (len_low[COUNT_BITS-1 -: 8] != 8'd0);
        end else begin
          hdr_cnt_next = hdr_cnt - 3'd1;
        end
      end
      PH_KEY: begin
        key_next = {key[23:0], rx_byte};
        if (hdr_cnt == 3'd0) begin
          if (len_low == '0) begin
            phase_next = PH_HDR0;
            ent.kind   = KIND_EMPTY;
            ent.last   = 1'b1;
          end else begin
            phase_next = PH_DATA;
          end
        end else begin
          hdr_cnt_next = hdr_cnt - 3'd1;
        end
      end
      PH_DATA: begin
        ent.kind     = KIND_DATA;
        ent.raw      = rx_byte;
        ent.key_byte = mask_on ? kbyte : 8'd0;
        idx_next     = idx_inc;
        if (idx_inc == len_low) begin
          ent.last   = 1'b1;
          phase_next = PH_HDR0;
        end
      end
      default: begin
        phase_next = PH_HALT;
        ent.kind   = KIND_HALTED;
      end
    endcase

    // length now complete: limit check and choice of the next phase
    if (known) begin
      if (kb || (CMP_BITS'(kl) > limit_ext)) begin
        phase_next = PH_HALT;
        ent.kind   = KIND_OVERSIZE;
      end else begin
        idx_next = '0;
        if (km) begin
          key_next     = '0;
          hdr_cnt_next = KEY_BYTES;
          phase_next   = PH_KEY;
        end else if (kl == '0) begin
          phase_next = PH_HDR0;
          ent.kind   = KIND_EMPTY;
          ent.last   = 1'b1;
        end else begin
          phase_next = PH_DATA;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_HDR0;
      opcode  <= '0;
      mask_on <= 1'b0;
      len_low <= '0;
      len_big <= 1'b0;
      hdr_cnt <= '0;
      key     <= '0;
      idx     <= '0;
    end else if (acc) begin
      phase   <= phase_next;
      opcode  <= opcode_next;
      mask_on <= mask_on_next;
      len_low <= len_low_next;
      len_big <= len_big_next;
      hdr_cnt <= hdr_cnt_next;
      key     <= key_next;
      idx     <= idx_next;
    end
  end

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HALT) |=> (phase == PH_HALT))
    else $error("left halted phase");

  a_last_to_hdr0: assert property (@(posedge clk) disable iff (rst)
    (acc && ent.last) |=> (phase == PH_HDR0))
    else $error("frame end did not return to first header byte");

endmodule

// File: rtl/wsd_queue.sv
`timescale 1ns / 1ps
// short queue between parser and output stage
module wsd_queue
  import wsd_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   wr,
  input  entry_t wr_data,
  input  logic   rd,
  output entry_t rd_data,
  output logic   q_full,
  output logic   q_empty
);

  entry_t               mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   count;

  assign q_full  = (count == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign q_empty = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + QPTR_BITS'(1);
      end
      if (rd) begin
        rd_ptr <= rd_ptr + QPTR_BITS'(1);
      end
      case ({wr, rd})
        2'b10: count <= count + (QPTR_BITS+1)'(1);
        2'b01: count <= count - (QPTR_BITS+1)'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !wr)
    else $error("write into full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QPTR_BITS+1)'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

endmodule

// File: rtl/wsd_back.sv
`timescale 1ns / 1ps
// output stage: unmasks payload and holds the waiting result word
module wsd_back
  import wsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  entry_t     q_data,
  output logic       q_rd,
  input  logic       pop,
  output logic       empty,
  output logic [2:0] kind,
  output logic [7:0] data_byte,
  output logic [3:0] frame_opcode,
  output logic       frame_last
);

  logic out_valid;

  assign empty = !out_valid;
  assign q_rd  = !q_empty && (!out_valid || pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_rd) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      kind         <= q_data.kind;
      data_byte    <= q_data.raw ^ q_data.key_byte;
      frame_opcode <= q_data.opcode;
      frame_last   <= q_data.last;
    end
  end

  a_fill_on_read: assert property (@(posedge clk) disable iff (rst)
    q_rd |=> out_valid)
    else $error("queue read left output empty");

endmodule

// File: tb/deframe_checker.sv
`timescale 1ns / 1ps
// checker for the websocket frame deframer: predicts each result word and compares it
module deframe_checker
  import wsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  rx_byte,
  input  logic        pop,
  input  logic        empty,
  input  logic [2:0]  kind,
  input  logic [7:0]  data_byte,
  input  logic [3:0]  frame_opcode,
  input  logic        frame_last,
  output int          errors,
  output int          pending
);

  localparam logic [2:0] LIMIT_ADDR = 3'(4 * REG_MAX_PAYLOAD);

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic [3:0] opcode;
    logic       last;
  } deframed_word_t;

  deframed_word_t        expected_words[$];
  logic [CFG_BITS-1:0]   payload_limit;
  phase_t                phase;
  logic [3:0]            opcode_q;
  logic                  masked;
  logic [63:0]           declared_len;
  logic [2:0]            bytes_left;
  logic [31:0]           key;
  logic [COUNT_BITS-1:0] payload_pos;

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic kind_t settle_length(output logic done);
    logic [63:0] cap;
    cap  = 64'(payload_limit);
    done = 1'b0;
    if (cap > (64'd1 << COUNT_BITS) - 64'd1) cap = (64'd1 << COUNT_BITS) - 64'd1;
    if (declared_len > cap) begin
      phase = PH_HALT;
      return KIND_OVERSIZE;
    end
    payload_pos = '0;
    if (masked) begin
      key        = '0;
      bytes_left = KEY_BYTES;
      phase      = PH_KEY;
      return KIND_HDR;
    end
    if (declared_len == 64'd0) begin
      phase = PH_HDR0;
      done  = 1'b1;
      return KIND_EMPTY;
    end
    phase = PH_DATA;
    return KIND_HDR;
  endfunction

  task automatic deframe_byte(input logic [7:0] b);
    deframed_word_t w;
    logic [7:0]     key_byte;
    logic           done;
    w        = '{kind: KIND_HDR, data: 8'd0, opcode: 4'd0, last: 1'b0};
    key_byte = 8'd0;
    done     = 1'b0;
    case (phase)
      PH_HDR0: begin
        opcode_q = 4'(b & OPCODE_MASK);
        phase    = PH_HDR1;
      end
      PH_HDR1: begin
        masked       = b[7];
        declared_len = '0;
        if (b[6:0] == LEN_EXT16) begin
          bytes_left = EXT16_BYTES;
          phase      = PH_EXTLEN;
        end else if (b[6:0] == LEN_EXT64) begin
          bytes_left = EXT64_BYTES;
          phase      = PH_EXTLEN;
        end else begin
          declared_len = 64'(b[6:0]);
          w.kind       = settle_length(done);
        end
      end
      PH_EXTLEN: begin
        declared_len = {declared_len[55:0], b};
        if (bytes_left == 3'd0) w.kind = settle_length(done);
        else bytes_left = bytes_left - 3'd1;
      end
      PH_KEY: begin
        key = {key[23:0], b};
        if (bytes_left == 3'd0) begin
          if (declared_len == 64'd0) begin
            phase  = PH_HDR0;
            w.kind = KIND_EMPTY;
            done   = 1'b1;
          end else begin
            phase = PH_DATA;
          end
        end else begin
          bytes_left = bytes_left - 3'd1;
        end
      end
      PH_DATA: begin
        if (masked) key_byte = key[8 * (3 - payload_pos[1:0]) +: 8];
        w.kind      = KIND_DATA;
        w.data      = b ^ key_byte;
        payload_pos = payload_pos + 1'b1;
        if (64'(payload_pos) == declared_len) begin
          done  = 1'b1;
          phase = PH_HDR0;
        end
      end
      default: begin
        phase  = PH_HALT;
        w.kind = KIND_HALTED;
      end
    endcase
    w.last   = done;
    w.opcode = opcode_q;
    expected_words.push_back(w);
  endtask

  function automatic void check_field(string name, logic [7:0] expv, logic [7:0] actv);
    if (actv !== expv) begin
      errors++;
      $error("%s: expected %0d, actual %0d", name, expv, actv);
    end
  endfunction

  always @(posedge clk) begin
    deframed_word_t w;
    if (rst) begin
      expected_words.delete();
      payload_limit = MAX_PAYLOAD_RESET;
      phase         = PH_HDR0;
      opcode_q      = '0;
      masked        = 1'b0;
      declared_len  = '0;
      bytes_left    = '0;
      key           = '0;
      payload_pos   = '0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == LIMIT_ADDR)
        payload_limit = pwdata[CFG_BITS-1:0];
      if (push && !full) deframe_byte(rx_byte);
      if (pop && !empty) begin
        if (expected_words.size() == 0) begin
          errors++;
          $error("result word with nothing expected: kind %0d data %0d", kind, data_byte);
        end else begin
          w = expected_words.pop_front();
          check_field("kind", 8'(w.kind), 8'(kind));
          check_field("data_byte", w.data, data_byte);
          check_field("frame_opcode", 8'(w.opcode), 8'(frame_opcode));
          check_field("frame_last", 8'(w.last), 8'(frame_last));
        end
      end
    end
    pending = expected_words.size();
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// testbench top for the websocket frame deframer: stimulus, pacing and verdict
module tb;
  import wsd_pkg::*;

  localparam logic [2:0] LIMIT_ADDR = 3'(4 * REG_MAX_PAYLOAD);
  localparam int FORM_SHORT = 0;
  localparam int FORM_EXT16 = 1;
  localparam int FORM_EXT64 = 2;
  localparam int PHASE_WORDS = 350;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        push = 1'b0;
  logic [7:0]  rx_byte = '0;
  logic        full;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  kind;
  logic [7:0]  data_byte;
  logic [3:0]  frame_opcode;
  logic        frame_last;

  int          errors;
  int          pending;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned frames = 0;
  int unsigned bytes_sent = 0;

  websocket_frame_deframer dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .push(push), .rx_byte(rx_byte), .full(full),
    .empty(empty), .pop(pop),
    .kind(kind), .data_byte(data_byte), .frame_opcode(frame_opcode),
    .frame_last(frame_last)
  );

  deframe_checker chk (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .push(push), .full(full), .rx_byte(rx_byte),
    .pop(pop), .empty(empty),
    .kind(kind), .data_byte(data_byte), .frame_opcode(frame_opcode),
    .frame_last(frame_last),
    .errors(errors), .pending(pending)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    if (rst) pop <= 1'b0;
    else pop <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // called and returns at a falling edge
  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    push    <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (full);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic drain();
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_limit(input logic [15:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= LIMIT_ADDR;
    pwdata  <= {16'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_length_header(input logic [63:0] len, input int form, input logic mask);
    send_byte(8'($urandom));
    case (form)
      FORM_SHORT: send_byte({mask, len[6:0]});
      FORM_EXT16: begin
        send_byte({mask, LEN_EXT16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      default: begin
        send_byte({mask, LEN_EXT64});
        for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
      end
    endcase
  endtask

  task automatic emit_frame(input int unsigned len, input int form);
    logic mask;
    mask = 1'($urandom);
    send_length_header(64'(len), form, mask);
    if (mask) repeat (4) send_byte(8'($urandom));
    repeat (len) send_byte(8'($urandom));
    frames++;
  endtask

  // mostly short frames, a few at the length cap; length forms include non-minimal ones
  task automatic send_frame(input int unsigned max_len);
    int unsigned len, r, cap;
    int          form;
    r   = $urandom_range(99);
    cap = (max_len < 160) ? max_len : 160;
    if (r < 70) len = $urandom_range((cap < 20) ? cap : 20);
    else if (r < 95) len = $urandom_range((cap < 300) ? cap : 300);
    else len = cap;
    r = $urandom_range(99);
    if (len <= 125) form = (r < 60) ? FORM_SHORT : (r < 85) ? FORM_EXT16 : FORM_EXT64;
    else form = (r < 80) ? FORM_EXT16 : FORM_EXT64;
    emit_frame(len, form);
  endtask

  initial begin
    logic [7:0]  directed[$];
    logic [63:0] big_len;
    int unsigned start_count, lim, r;
    int unsigned idle_tab[4];
    int unsigned stall_tab[4];
    idle_tab  = '{0, 79, 0, 34};
    stall_tab = '{0, 0, 79, 34};
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty plain frame, masked one-byte frame, 16-bit length, empty 64-bit length
    directed = '{8'h81, 8'h00,
                 8'hFF, 8'h81, 8'hFF, 8'h00, 8'hAA, 8'h55, 8'h5A,
                 8'h08, 8'h7E, 8'h00, 8'h02, 8'h00, 8'hFF,
                 8'h09, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    foreach (directed[i]) send_byte(directed[i]);
    frames += 4;

    for (int p = 0; p < 4; p++) begin
      drain();
      send_idle_pct = idle_tab[p];
      stall_pct     = stall_tab[p];
      case (p)
        0: lim = 65535;
        1: lim = 0;
        2: lim = $urandom_range(300, 1);
        default: lim = $urandom_range(4080, 126);
      endcase
      write_limit(16'(lim));
      start_count = bytes_sent;
      while (bytes_sent - start_count < PHASE_WORDS) send_frame(lim);
    end

    // oversize frame, then every later word reports halted
    drain();
    send_idle_pct = 0;
    stall_pct     = 0;
    r = $urandom_range(3);
    case (r)
      0: begin
        lim = $urandom_range(124);
        write_limit(16'(lim));
        send_length_header(64'($urandom_range(125, lim + 1)), FORM_SHORT, 1'($urandom));
      end
      1: begin
        lim = $urandom_range(65534);
        write_limit(16'(lim));
        send_length_header(64'($urandom_range(65535, lim + 1)),
                           $urandom_range(1) ? FORM_EXT16 : FORM_EXT64, 1'($urandom));
      end
      2: begin
        write_limit(16'($urandom));
        big_len = {$urandom, $urandom} | 64'h8000_0000_0000_0000;
        send_length_header(big_len, FORM_EXT64, 1'($urandom));
      end
      default: begin
        write_limit(16'hFFFF);
        big_len = 64'h1_0000 + 64'($urandom_range(65535));
        send_length_header(big_len, FORM_EXT64, 1'($urandom));
      end
    endcase
    repeat (12) send_byte(8'($urandom));
    drain();
    repeat (8) @(negedge clk);

    $display("run covered %0d frames in %0d words over four pacing phases,", frames, bytes_sent);
    $display("payload limits from 0 to 65535, and an oversize frame followed by halted words");
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
